@@ sv/i2dt_pkg.sv @@
`default_nettype none

package i2dt_pkg;

    // Width of the signed value taken from {value_high, value_low}
    localparam int VALUE_BITS = 128;

    // Decimal digits needed for a magnitude up to 2^(VALUE_BITS-1)
    localparam int DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS  = DIGITS * 4;
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS);
    localparam int MAX_CHARS = 40;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // One queued value: sign and unsigned magnitude
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    // One output character word
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } char_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ sv/i2dt_front.sv @@
`default_nettype none

module i2dt_front
    import i2dt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] value_high,
    input  wire logic [63:0] value_low,
    output logic             item_valid,
    output item_t            item,
    input  wire logic        item_take
);

    logic [127:0]          raw;
    logic [VALUE_BITS-1:0] value;
    logic                  sign;
    item_t                 in_item;
    logic                  accept;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Sign and magnitude of the incoming word
    always_comb
    begin
        raw   = {value_high, value_low};
        value = raw[VALUE_BITS-1:0];
        sign  = value[VALUE_BITS-1];
        in_item.neg = sign;
        in_item.mag = sign ? (~value + 1'b1) : value;
    end

    assign full       = (count_reg == 2'd2);
    assign accept     = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (item_take && item_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, accept} - {1'b0, item_take && item_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/i2dt_back.sv @@
`default_nettype none

module i2dt_back
    import i2dt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       item_take,
    input  wire logic  out_space,
    output logic       out_wr,
    output char_t      out_word
);

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_BITS-1:0]    bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic                   started_reg, started_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;

    logic [BCD_BITS-1:0]    adj;
    logic [3:0]             top;
    logic                   last_dig;

    // Add-3 correction on every BCD digit before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                            bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    assign top      = bcd_reg[BCD_BITS-1 -: 4];
    assign last_dig = (dig_cnt_reg == '0);

    // Sequencer: load, double-dabble, emit minus sign and digits from the top
    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        item_take    = 1'b0;
        out_wr       = 1'b0;
        out_word     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_take    = 1'b1;
                    bin_next     = item.mag;
                    neg_next     = item.neg;
                    bcd_next     = '0;
                    started_next = 1'b0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(DIGITS - 1);
                    state_next   = ST_EMIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_space)
                begin
                    if (neg_reg)
                    begin
                        // minus sign first; a negative magnitude is never zero
                        out_wr             = 1'b1;
                        out_word.text_char = CH_MINUS;
                        out_word.is_last   = 1'b0;
                        neg_next           = 1'b0;
                    end
                    else
                    begin
                        // skip leading zeros, units digit always printed
                        if (started_reg || top != 4'd0 || last_dig)
                        begin
                            out_wr             = 1'b1;
                            out_word.text_char = CH_ZERO + {4'd0, top};
                            out_word.is_last   = last_dig;
                            started_next       = 1'b1;
                        end
                        bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
                        if (last_dig)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            dig_cnt_next = dig_cnt_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

endmodule

`default_nettype wire

@@ sv/i2dt_outq.sv @@
`default_nettype none

module i2dt_outq
    import i2dt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr,
    input  wire char_t       wr_word,
    output logic             space,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       text_char,
    output logic             is_last
);

    char_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign space     = (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_wr     = wr && space;
    assign do_rd     = pop && !empty;
    assign text_char = entry_reg[rd_ptr_reg].text_char;
    assign is_last   = entry_reg[rd_ptr_reg].is_last;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

`default_nettype wire

@@ sv/int128_to_decimal_text.sv @@
// Channel  | Ports                        | Handshake
// ---------+------------------------------+----------------------------
// values   | value_high, value_low        | push / full
// text     | text_char, is_last           | pop / empty (oldest word shown)
//
// Each value is loaded, then takes VALUE_BITS steps of shift-add-3 in the back
// end, then one step per BCD digit position (DIGITS) plus one for a minus sign.
// A two-entry queue takes new values while the back end works; a two-entry
// output queue holds text words. A stalled pop only holds the emit step.
// Reset clears all queues and the sequencer.
`default_nettype none

module int128_to_decimal_text
    import i2dt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] value_high,
    input  wire logic [63:0] value_low,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       text_char,
    output logic             is_last
);

    logic  item_valid;
    item_t item;
    logic  item_take;
    logic  out_space;
    logic  out_wr;
    char_t out_word;

    i2dt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value_high (value_high),
        .value_low  (value_low),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    i2dt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_space  (out_space),
        .out_wr     (out_wr),
        .out_word   (out_word)
    );

    i2dt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (out_wr),
        .wr_word   (out_word),
        .space     (out_space),
        .pop       (pop),
        .empty     (empty),
        .text_char (text_char),
        .is_last   (is_last)
    );

endmodule

`default_nettype wire

@@ sv/i2dt_checker.sv @@
`default_nettype none

module i2dt_checker
    import i2dt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pop,
    input  wire logic       empty,
    input  wire logic [7:0] text_char,
    input  wire logic       is_last
);

    // A waiting word stays until popped
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("text word withdrawn before pop");

    // A waiting word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(text_char) && $stable(is_last)))
        else $error("text word changed while waiting");

    // Only a minus sign or a decimal digit is emitted
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (text_char == CH_MINUS ||
                    (text_char >= CH_ZERO && text_char <= CH_ZERO + 8'd9)))
        else $error("illegal text character");

    // A minus sign is always followed by digits
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_char == CH_MINUS) |-> !is_last)
        else $error("minus sign marked as last");

endmodule

bind int128_to_decimal_text i2dt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .empty     (empty),
    .text_char (text_char),
    .is_last   (is_last)
);

`default_nettype wire

@@ tb/sv/decimal_text_checker.sv @@
`timescale 1ns / 100ps

module decimal_text_checker
    import i2dt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [63:0] value_high,
    input  logic [63:0] value_low,
    input  logic        pop,
    input  logic        empty,
    input  logic [7:0]  text_char,
    input  logic        is_last,
    output int          fail_count,
    output int          pending
);

    // Characters still owed by the block, oldest first
    char_t due_chars[$];
    char_t head;
    int    mismatches = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Appends the decimal text of one accepted value to due_chars
    function automatic void format_decimal(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] v;
        logic [127:0] mag;
        logic         neg;
        logic [7:0]   digs[$];
        char_t        c;
        int           i;
        v = {hi, lo};
        // sign-extend from the configured width
        for (i = VALUE_BITS; i < 128; i++)
            v[i] = v[VALUE_BITS-1];
        neg = v[127];
        mag = neg ? (~v + 128'd1) : v;
        if (mag == 128'd0)
        begin
            c.text_char = CH_ZERO;
            c.is_last   = 1'b1;
            due_chars.push_back(c);
            return;
        end
        while (mag != 128'd0)
        begin
            digs.push_front(CH_ZERO + 8'(mag % 128'd10));
            mag = mag / 128'd10;
        end
        if (neg)
        begin
            c.text_char = CH_MINUS;
            c.is_last   = 1'b0;
            due_chars.push_back(c);
        end
        for (i = 0; i < digs.size(); i++)
        begin
            c.text_char = digs[i];
            c.is_last   = (i == digs.size() - 1);
            due_chars.push_back(c);
        end
    endfunction

    // Check popped words first, then predict from the accepted value
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (due_chars.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got char %0d last %0b",
                             $time, text_char, is_last);
                    mismatches++;
                end
                else
                begin
                    head = due_chars.pop_front();
                    if (text_char !== head.text_char)
                    begin
                        $display("%0t: text_char expected %0d got %0d",
                                 $time, head.text_char, text_char);
                        mismatches++;
                    end
                    if (is_last !== head.is_last)
                    begin
                        $display("%0t: is_last expected %0b got %0b",
                                 $time, head.is_last, is_last);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
                format_decimal(value_high, value_low);
        end
        fail_count <= mismatches;
        pending    <= due_chars.size();
    end

endmodule

@@ tb/sv/tb_int128_to_decimal_text.sv @@
`timescale 1ns / 100ps

module tb_int128_to_decimal_text;
    import i2dt_pkg::*;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic [63:0] value_high = 64'd0;
    logic [63:0] value_low  = 64'd0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  text_char;
    logic        is_last;
    int          fail_count;
    int          pending;

    // No idle gaps on either side once set
    bit calm = 1'b0;

    always #5 clk = ~clk;

    int128_to_decimal_text dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value_high (value_high),
        .value_low  (value_low),
        .pop        (pop),
        .empty      (empty),
        .text_char  (text_char),
        .is_last    (is_last)
    );

    decimal_text_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value_high (value_high),
        .value_low  (value_low),
        .pop        (pop),
        .empty      (empty),
        .text_char  (text_char),
        .is_last    (is_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one value, with an optional idle burst first; returns at the accepting edge
    task automatic send_value(input logic [63:0] hi, input logic [63:0] lo);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push       <= 1'b1;
        value_high <= hi;
        value_low  <= lo;
        do
            @(posedge clk);
        while (full);
    endtask

    // Wait until every predicted character has been popped
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Text reader: random stall bursts, one long hold-off to back the block up
    initial
    begin : reader
        int  stall_left;
        int  words_out;
        bit  held;
        stall_left = 0;
        words_out  = 0;
        held       = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                words_out++;
            if (!held && words_out >= 100)
            begin
                held       = 1'b1;
                stall_left = 1500;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Value stimulus and verdict
    initial
    begin : stimulus
        logic [127:0] w;
        logic [127:0] r;
        int           n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, small values and sign edges
        send_value(64'd0, 64'd0);
        send_value(64'd0, 64'd1);
        send_value('1, '1);
        send_value(64'd0, 64'd9);
        send_value(64'd0, 64'd10);
        send_value('1, -64'sd10);
        // most negative and largest positive at the configured width
        w = 128'd1 << (VALUE_BITS - 1);
        send_value(w[127:64], w[63:0]);
        w = w - 128'd1;
        send_value(w[127:64], w[63:0]);
        send_value(64'h8000_0000_0000_0000, 64'd0);
        send_value(64'h7FFF_FFFF_FFFF_FFFF, '1);
        // carries and borrows across the 64-bit halves
        send_value(64'd0, '1);
        send_value(64'd1, 64'd0);
        send_value('1, 64'd0);
        send_value('1, 64'h8000_0000_0000_0000);
        send_value(64'd0, 64'h8AC7_2304_89E8_0000);
        send_value(64'h4B3B_4CA8_5A86_C47A, 64'h098A_2240_0000_0000);
        send_value(64'h4B3B_4CA8_5A86_C47A, 64'h098A_223F_FFFF_FFFF);
        // toggle every bit both ways
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_value(64'd0, 64'd99);
        send_value('1, -64'sd100);

        // let everything drain before the random part
        push <= 1'b0;
        wait_drained();

        for (n = 0; n < 480; n++)
        begin
            if (n == 420)
                calm = 1'b1;
            r = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       w = r;
                1:       w = 128'($urandom_range(0, 20));
                2:       w = r >> $urandom_range(0, 127);
                default: w = (128'd1 << $urandom_range(0, 127))
                             + 128'($urandom_range(0, 4)) - 128'd2;
            endcase
            if ($urandom_range(0, 1) == 1)
                w = ~w + 128'd1;
            send_value(w[127:64], w[63:0]);
        end
        push <= 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
